@@ sv/utf8_lowercase_key_transcoder_assert.svh @@
// ----------------------------------------------------------------------------
// utf8_lowercase_key_transcoder_assert
// Assertion macros shared by the key transcoder modules.
// Each macro expects i_clk and i_rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef UTF8_LOWERCASE_KEY_TRANSCODER_ASSERT_SVH
`define UTF8_LOWERCASE_KEY_TRANSCODER_ASSERT_SVH

// Same-cycle implication.
`define ULKT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ULKT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/ulkt_pkg.sv @@
// ----------------------------------------------------------------------------
// ulkt_pkg
// Types, constants and the lowercase/encode functions of the key transcoder.
// ----------------------------------------------------------------------------
package ulkt_pkg;

    localparam int CP_W = 21;

    localparam logic [CP_W-1:0] CP_MAX     = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO    = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI    = 21'h00DFFF;
    localparam logic [CP_W-1:0] MIN_3BYTE  = 21'h000800;
    localparam logic [CP_W-1:0] MIN_4BYTE  = 21'h010000;

    typedef enum logic [1:0] {
        RES_NONE,
        RES_CP,
        RES_BAD
    } t_res_kind;

    // Decoder outcome for one accepted byte
    typedef struct packed {
        t_res_kind        kind;
        logic             last;
        logic [CP_W-1:0]  cp;
    } t_dec_res;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      n;
    } t_enc;

    function automatic logic [CP_W-1:0] lower_map(input logic [CP_W-1:0] c);
        logic even;
        logic [CP_W-1:0] r;
        even = ~c[0];
        r    = c;
        if (c >= 21'h41 && c <= 21'h5A) begin
            r = c + 21'h20;
        end else if ((c >= 21'hC0 && c <= 21'hD6) || (c >= 21'hD8 && c <= 21'hDE)) begin
            r = c + 21'h20;
        end else if (c == 21'h0178) begin
            r = 21'h00FF;
        end else if (c == 21'h0130) begin
            r = 21'h0069;
        end else if (even && ((c >= 21'h0100 && c <= 21'h012F) ||
                              (c >= 21'h0132 && c <= 21'h0137) ||
                              (c >= 21'h014A && c <= 21'h0177) ||
                              (c >= 21'h1E00 && c <= 21'h1EFF))) begin
            r = c + 21'h1;
        end else if (!even && ((c >= 21'h0139 && c <= 21'h0147) ||
                               (c >= 21'h0179 && c <= 21'h017D))) begin
            r = c + 21'h1;
        end
        return r;
    endfunction

    function automatic t_enc encode(input logic [CP_W-1:0] c);
        t_enc e;
        e.bytes = '0;
        if (c < 21'h80) begin
            e.bytes[0] = c[7:0];
            e.n        = 3'd1;
        end else if (c < MIN_3BYTE) begin
            e.bytes[0] = {3'b110, c[10:6]};
            e.bytes[1] = {2'b10, c[5:0]};
            e.n        = 3'd2;
        end else if (c < MIN_4BYTE) begin
            e.bytes[0] = {4'b1110, c[15:12]};
            e.bytes[1] = {2'b10, c[11:6]};
            e.bytes[2] = {2'b10, c[5:0]};
            e.n        = 3'd3;
        end else begin
            e.bytes[0] = {5'b11110, c[20:18]};
            e.bytes[1] = {2'b10, c[17:12]};
            e.bytes[2] = {2'b10, c[11:6]};
            e.bytes[3] = {2'b10, c[5:0]};
            e.n        = 3'd4;
        end
        return e;
    endfunction

endpackage

@@ sv/ulkt_decode.sv @@
// ----------------------------------------------------------------------------
// ulkt_decode
// Strict UTF-8 decoder: sequence state and the per-byte outcome.
// ----------------------------------------------------------------------------
module ulkt_decode (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_byte,
    input  logic               i_last,
    output ulkt_pkg::t_dec_res o_res
);
    import ulkt_pkg::*;

    logic [1:0]      r_pending, n_pending;
    logic [1:0]      r_seq_len, n_seq_len;
    logic [CP_W-1:0] r_accum,   n_accum;
    logic            r_poisoned, n_poisoned;

    logic [CP_W-1:0] acc;
    logic [CP_W-1:0] cp;
    logic            done;

    always_comb begin
        n_pending  = r_pending;
        n_seq_len  = r_seq_len;
        n_accum    = r_accum;
        n_poisoned = r_poisoned;
        acc        = {r_accum[CP_W-7:0], i_byte[5:0]};
        cp         = '0;
        done       = 1'b0;

        if (!r_poisoned) begin
            if (r_pending == 2'd0) begin
                priority if (i_byte < 8'h80) begin
                    cp   = {13'd0, i_byte};
                    done = 1'b1;
                end else if (i_byte >= 8'hC2 && i_byte <= 8'hDF) begin
                    n_accum = {16'd0, i_byte[4:0]};
                    n_seq_len = 2'd1;
                    n_pending = 2'd1;
                end else if (i_byte >= 8'hE0 && i_byte <= 8'hEF) begin
                    n_accum = {17'd0, i_byte[3:0]};
                    n_seq_len = 2'd2;
                    n_pending = 2'd2;
                end else if (i_byte >= 8'hF0 && i_byte <= 8'hF4) begin
                    n_accum = {18'd0, i_byte[2:0]};
                    n_seq_len = 2'd3;
                    n_pending = 2'd3;
                end else begin
                    n_poisoned = 1'b1;
                end
            end else if (i_byte[7:6] != 2'b10) begin
                n_poisoned = 1'b1;
                n_pending  = 2'd0;
            end else begin
                n_accum   = acc;
                n_pending = r_pending - 2'd1;
                if (r_pending == 2'd1) begin
                    // overlong, above range or surrogate
                    if ((r_seq_len == 2'd2 && acc < MIN_3BYTE) ||
                        (r_seq_len == 2'd3 && acc < MIN_4BYTE) ||
                        acc > CP_MAX || (acc >= SURR_LO && acc <= SURR_HI)) begin
                        n_poisoned = 1'b1;
                    end else begin
                        cp   = acc;
                        done = 1'b1;
                    end
                    n_seq_len = 2'd0;
                    n_accum   = '0;
                end
            end
        end

        if (i_last) begin
            n_pending  = 2'd0;
            n_seq_len  = 2'd0;
            n_accum    = '0;
            n_poisoned = 1'b0;
        end
    end

    always_comb begin
        o_res.last = i_last;
        o_res.cp   = cp;
        priority if (done) begin
            o_res.kind = RES_CP;
        end else if (i_last) begin
            o_res.kind = RES_BAD;
        end else begin
            o_res.kind = RES_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending  <= 2'd0;
            r_seq_len  <= 2'd0;
            r_accum    <= '0;
            r_poisoned <= 1'b0;
        end else if (i_accept) begin
            r_pending  <= n_pending;
            r_seq_len  <= n_seq_len;
            r_accum    <= n_accum;
            r_poisoned <= n_poisoned;
        end
    end

`include "utf8_lowercase_key_transcoder_assert.svh"

    `ULKT_ASSERT_NOW(a_poison_no_pending, r_poisoned, r_pending == 2'd0, "poisoned with bytes pending")
    `ULKT_ASSERT_NOW(a_pending_le_len, 1'b1, r_pending <= r_seq_len, "pending exceeds sequence length")
    `ULKT_ASSERT_NEXT(a_last_clears, i_accept && i_last, r_pending == 2'd0 && !r_poisoned, "state not cleared at string end")

endmodule

@@ sv/utf8_lowercase_key_transcoder.sv @@
// ----------------------------------------------------------------------------
// utf8_lowercase_key_transcoder
// Strict UTF-8 decode, simple Latin lowercase, re-encode into key bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one raw string byte per transaction in s_axis_tdata, with
//   s_axis_tlast on the final byte of the string.
//   Master stream: one key byte per transaction. tdata[8] flags the last byte
//   produced by one input byte, m_axis_tlast marks the end of the key and
//   m_axis_tuser flags a bad key (a single zero byte replaces the key tail).
// Latency: results of an input byte appear the cycle after it is accepted.
// Throughput: one input byte per cycle while m_axis_tready is high and each
//   gives at most one output byte; one that expands into more bytes holds the
//   output register until all are taken; input is taken again as its last
//   one pops. Bytes yielding nothing (mid-sequence, after an error) add none.
// Stall: while m_axis_tready is low the result register holds and
//   s_axis_tready drops once a new item would overwrite it.
// Reset: synchronous, active low; decoder state and output count clear and
//   the block is ready the first cycle after reset.
// ----------------------------------------------------------------------------
module utf8_lowercase_key_transcoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // in_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [8] run_last, rest zero
    output logic        m_axis_tlast,   // key_end
    output logic        m_axis_tuser    // [0] key_bad
);
    import ulkt_pkg::*;

    t_dec_res        dec_res;
    t_enc            enc;
    logic            in_accept;
    logic            out_pop;

    logic [3:0][7:0] r_bytes, n_bytes;
    logic [2:0]      r_cnt,   n_cnt;
    logic            r_last,  n_last;
    logic            r_bad,   n_bad;

    assign out_pop       = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (r_cnt == 3'd0) || (r_cnt == 3'd1 && m_axis_tready);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    ulkt_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_byte   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_res    (dec_res)
    );

    assign enc = encode(lower_map(dec_res.cp));

    always_comb begin
        n_bytes = r_bytes;
        n_cnt   = r_cnt;
        n_last  = r_last;
        n_bad   = r_bad;
        if (out_pop) begin
            n_bytes = {8'h00, r_bytes[3:1]};
            n_cnt   = r_cnt - 3'd1;
        end
        if (in_accept) begin
            priority if (dec_res.kind == RES_CP) begin
                n_bytes = enc.bytes;
                n_cnt   = enc.n;
                n_last  = dec_res.last;
                n_bad   = 1'b0;
            end else if (dec_res.kind == RES_BAD) begin
                n_bytes = '0;
                n_cnt   = 3'd1;
                n_last  = 1'b1;
                n_bad   = 1'b1;
            end else begin
                n_bytes = n_bytes;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes <= n_bytes;
        r_last  <= n_last;
        r_bad   <= n_bad;
    end

    assign m_axis_tvalid = (r_cnt != 3'd0);
    assign m_axis_tdata  = {7'd0, (r_cnt == 3'd1), r_bytes[0]};
    assign m_axis_tlast  = (r_cnt == 3'd1) && r_last;
    assign m_axis_tuser  = r_bad;

`include "utf8_lowercase_key_transcoder_assert.svh"

    `ULKT_ASSERT_NOW(a_cnt_range, 1'b1, r_cnt <= 3'd4, "output count out of range")
    `ULKT_ASSERT_NOW(a_accept_drains, in_accept, r_cnt <= 3'd1, "input taken over pending output")
    `ULKT_ASSERT_NOW(a_bad_marker, m_axis_tvalid && m_axis_tuser, m_axis_tlast && r_cnt == 3'd1 && r_bytes[0] == 8'h00, "malformed bad-key marker")
    `ULKT_ASSERT_NEXT(a_drain_idle, out_pop && r_cnt == 3'd1 && !in_accept, !m_axis_tvalid, "output valid after final pop")

endmodule

@@ bench/tb_utf8_lowercase_key_transcoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_lowercase_key_transcoder
// Streams strings byte by byte into the transcoder and checks every key byte
// against a local decoder/lowercase/encoder, with random gaps on the input and
// random back-pressure on the output. Directed strings cover parts of the case map and
// each decode error; random strings are mostly well-formed UTF-8.
// ----------------------------------------------------------------------------
module tb_utf8_lowercase_key_transcoder;

    typedef logic [7:0] t_byte_q[$];

    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       key_end;
        logic       key_bad;
    } t_key_byte;

    typedef struct packed {
        logic [2:0]      len;
        logic [3:0][7:0] seq;
    } t_utf8_seq;

    localparam logic [20:0] MAX_SCALAR   = 21'h10FFFF;
    localparam logic [20:0] SURROGATE_LO = 21'h00D800;
    localparam logic [20:0] SURROGATE_HI = 21'h00DFFF;
    localparam int          RANDOM_BYTES = 160;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;     // [7:0] in_byte
    logic        s_axis_tlast = 1'b0;      // in_last
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;             // [7:0] out_byte, [8] run_last, rest zero
    logic        m_axis_tlast;             // key_end
    logic        m_axis_tuser;             // [0] key_bad

    // decoder state of the predictor
    logic [1:0]  dec_pending = 2'd0;
    logic [1:0]  dec_len = 2'd0;
    logic [20:0] dec_cp = 21'd0;
    logic        dec_poisoned = 1'b0;

    t_key_byte   key_bytes_q[$];
    int          mismatches = 0;
    int          bytes_sent = 0;
    int          strings_sent = 0;
    int          results_seen = 0;
    int          bad_keys_seen = 0;
    logic        no_idle = 1'b0;

    utf8_lowercase_key_transcoder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic between(input logic [20:0] c, input logic [20:0] lo,
                                     input logic [20:0] hi);
        return (c >= lo) && (c <= hi);
    endfunction

    function automatic logic [20:0] fold_case(input logic [20:0] c);
        logic [20:0] r;
        r = c;
        if (between(c, 21'h41, 21'h5A) || between(c, 21'hC0, 21'hD6) ||
            between(c, 21'hD8, 21'hDE)) begin
            r = c + 21'h20;
        end else if (c == 21'h0178) begin
            r = 21'h00FF;
        end else if (c == 21'h0130) begin
            r = 21'h0069;
        end else if (!c[0] && (between(c, 21'h0100, 21'h012F) ||
                               between(c, 21'h0132, 21'h0137) ||
                               between(c, 21'h014A, 21'h0177) ||
                               between(c, 21'h1E00, 21'h1EFF))) begin
            r = c + 21'h1;
        end else if (c[0] && (between(c, 21'h0139, 21'h0147) ||
                              between(c, 21'h0179, 21'h017D))) begin
            r = c + 21'h1;
        end
        return r;
    endfunction

    function automatic t_utf8_seq utf8_encode(input logic [20:0] c);
        t_utf8_seq r;
        r.seq = '0;
        if (c < 21'h80) begin
            r.len    = 3'd1;
            r.seq[0] = c[7:0];
        end else if (c < 21'h800) begin
            r.len    = 3'd2;
            r.seq[0] = {3'b110, c[10:6]};
            r.seq[1] = {2'b10, c[5:0]};
        end else if (c < 21'h10000) begin
            r.len    = 3'd3;
            r.seq[0] = {4'b1110, c[15:12]};
            r.seq[1] = {2'b10, c[11:6]};
            r.seq[2] = {2'b10, c[5:0]};
        end else begin
            r.len    = 3'd4;
            r.seq[0] = {5'b11110, c[20:18]};
            r.seq[1] = {2'b10, c[17:12]};
            r.seq[2] = {2'b10, c[11:6]};
            r.seq[3] = {2'b10, c[5:0]};
        end
        return r;
    endfunction

    // Runs one accepted byte through the decoder and queues the key bytes it yields
    function automatic void predict_key_bytes(input logic [7:0] b, input logic last);
        logic        done;
        logic [20:0] cp;
        t_utf8_seq   enc;
        t_key_byte   kb;
        done = 1'b0;
        cp   = '0;
        if (!dec_poisoned) begin
            if (dec_pending == 2'd0) begin
                if (b < 8'h80) begin
                    cp   = {13'd0, b};
                    done = 1'b1;
                end else if (b >= 8'hC2 && b <= 8'hDF) begin
                    dec_cp = {16'd0, b[4:0]}; dec_len = 2'd1; dec_pending = 2'd1;
                end else if (b >= 8'hE0 && b <= 8'hEF) begin
                    dec_cp = {17'd0, b[3:0]}; dec_len = 2'd2; dec_pending = 2'd2;
                end else if (b >= 8'hF0 && b <= 8'hF4) begin
                    dec_cp = {18'd0, b[2:0]}; dec_len = 2'd3; dec_pending = 2'd3;
                end else begin
                    dec_poisoned = 1'b1;
                end
            end else if (b[7:6] != 2'b10) begin
                dec_poisoned = 1'b1;
                dec_pending  = 2'd0;
            end else begin
                dec_cp      = {dec_cp[14:0], b[5:0]};
                dec_pending = dec_pending - 2'd1;
                if (dec_pending == 2'd0) begin
                    // overlong, out of range and surrogates are caught on completion
                    if ((dec_len == 2'd2 && dec_cp < 21'h800) ||
                        (dec_len == 2'd3 && dec_cp < 21'h10000) ||
                        dec_cp > MAX_SCALAR ||
                        between(dec_cp, SURROGATE_LO, SURROGATE_HI)) begin
                        dec_poisoned = 1'b1;
                    end else begin
                        cp   = dec_cp;
                        done = 1'b1;
                    end
                    dec_len = 2'd0;
                    dec_cp  = '0;
                end
            end
        end

        if (done) begin
            enc = utf8_encode(fold_case(cp));
            for (int k = 0; k < enc.len; k++) begin
                kb.data    = enc.seq[k];
                kb.run_end = (k == enc.len - 1);
                kb.key_end = (k == enc.len - 1) && last;
                kb.key_bad = 1'b0;
                key_bytes_q.insert(key_bytes_q.size(), kb);
            end
        end else if (last) begin
            // poisoned or truncated string: single bad-key marker
            kb = '{8'h00, 1'b1, 1'b1, 1'b1};
            key_bytes_q.insert(key_bytes_q.size(), kb);
        end
        if (last) begin
            dec_pending  = 2'd0;
            dec_len      = 2'd0;
            dec_cp       = '0;
            dec_poisoned = 1'b0;
        end
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_idle();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = pick_idle();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_key_bytes(b, last);
        bytes_sent++;
    endtask

    task automatic send_string(input t_byte_q s);
        for (int i = 0; i < s.size(); i++)
            send_byte(s[i], i == s.size() - 1);
        strings_sent++;
    endtask

    // Output side back-pressure
    initial begin
        int hold;
        @(posedge i_clk);
        forever begin
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
            hold = pick_idle();
            if (hold > 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_key_byte got;
        t_key_byte want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tdata[7:0], m_axis_tdata[8], m_axis_tlast, m_axis_tuser};
            results_seen++;
            if (got.key_bad)
                bad_keys_seen++;
            if (key_bytes_q.size() == 0) begin
                note_mismatch($sformatf(
                    "unexpected key byte %02h run_last %b key_end %b key_bad %b",
                    got.data, got.run_end, got.key_end, got.key_bad));
            end else begin
                want = key_bytes_q.pop_front();
                if (got.data !== want.data || got.run_end !== want.run_end ||
                    got.key_end !== want.key_end || got.key_bad !== want.key_bad) begin
                    note_mismatch($sformatf(
                        "expected %02h/%b/%b/%b got %02h/%b/%b/%b (byte/run_last/key_end/key_bad)",
                        want.data, want.run_end, want.key_end, want.key_bad,
                        got.data, got.run_end, got.key_end, got.key_bad));
                end
            end
        end
    end

    task automatic test_ascii_keys();
        t_byte_q s;
        s = {8'h00, 8'h41, 8'h7F};
        send_string(s);
        s = {8'h5A};
        send_string(s);
    endtask

    task automatic test_multibyte_fold();
        t_byte_q s;
        // A-grave, Y-diaeresis, dotted capital I
        s = {8'hC3, 8'h80, 8'hC5, 8'hB8, 8'hC4, 8'hB0};
        send_string(s);
        // Latin extended additional, then the largest scalar
        s = {8'hE1, 8'hB8, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_string(s);
    endtask

    task automatic test_decode_errors();
        t_byte_q s;
        s = {8'hC0, 8'h41, 8'hFF};          // bad lead, rest of string dropped
        send_string(s);
        s = {8'hE0, 8'h80, 8'h80};          // overlong
        send_string(s);
        s = {8'hED, 8'hA0, 8'h80};          // surrogate
        send_string(s);
        s = {8'hF4, 8'h90, 8'h80, 8'h80};   // above 10FFFF
        send_string(s);
        s = {8'hC3, 8'h41};                 // bad continuation
        send_string(s);
        s = {8'hE1, 8'hB8};                 // cut off by end of string
        send_string(s);
    endtask

    function automatic logic [20:0] pick_code_point();
        logic [20:0] c;
        case ($urandom_range(0, 7))
            0, 1: c = 21'($urandom_range(0, 21'h7F));
            2:    c = 21'($urandom_range(21'hC0, 21'h17F));
            3:    c = 21'($urandom_range(21'h1E00, 21'h1EFF));
            4:    c = 21'($urandom_range(21'h80, 21'h7FF));
            5: begin
                c = 21'($urandom_range(21'h800, 21'hF7FF));
                if (c >= SURROGATE_LO)
                    c = c + 21'h800;
            end
            6:    c = 21'($urandom_range(21'h10000, MAX_SCALAR));
            default: begin
                case ($urandom_range(0, 7))
                    0: c = 21'h7F;
                    1: c = 21'h80;
                    2: c = 21'h7FF;
                    3: c = 21'h800;
                    4: c = 21'hD7FF;
                    5: c = 21'hE000;
                    6: c = 21'hFFFF;
                    default: c = 21'h10000;
                endcase
            end
        endcase
        return c;
    endfunction

    task automatic test_random_keys();
        t_byte_q   s;
        t_utf8_seq enc;
        int        flavor;
        int        start;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES) begin
            s.delete();
            flavor = $urandom_range(0, 9);
            if (flavor == 9) begin
                // raw noise
                repeat ($urandom_range(1, 6)) s.insert(s.size(), 8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    enc = utf8_encode(pick_code_point());
                    for (int k = 0; k < enc.len; k++)
                        s.insert(s.size(), enc.seq[k]);
                end
                if (flavor == 7)
                    s[$urandom_range(0, s.size() - 1)] = 8'($urandom_range(0, 255));
                else if (flavor == 8 && s.size() > 1)
                    void'(s.pop_back());
            end
            if ($urandom_range(0, 7) == 0)
                no_idle = !no_idle;
            send_string(s);
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_ascii_keys();
        test_multibyte_fold();
        test_decode_errors();
        test_random_keys();
        s_axis_tvalid <= 1'b0;

        while (key_bytes_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (key_bytes_q.size() != 0) begin
            mismatches += key_bytes_q.size();
            $display("%0d expected key bytes never came out", key_bytes_q.size());
        end

        $display("Covered %0d strings, %0d input bytes;", strings_sent, bytes_sent);
        $display("%0d key bytes checked, %0d bad-key markers", results_seen, bad_keys_seen);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timed out waiting for the transcoder");
        $display("Mismatches found");
        $finish;
    end

endmodule
